>>> sv/rfcs_pkg.sv
`timescale 1ns / 1ps

package rfcs_pkg;

    localparam int MAX_PANEL_SIDE = 512;
    localparam int SIDE_BITS      = 10;
    localparam int OFFSET_BITS    = 9;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 10;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_OFFSET = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_OFFSET    = 2'd3;

    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_ROW    = 8'h2B;
    localparam logic [7:0] CMD_WRITE  = 8'h2C;

    typedef struct packed {
        logic        kind;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] span_x;
        logic [15:0] span_y;
        logic [15:0] fill_rgb;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       final_byte;
    } t_out_item;

    // Classified work handed from the front to the back.
    typedef struct packed {
        logic                 kind;
        logic [15:0]          x0;
        logic [15:0]          x1;
        logic [15:0]          y0;
        logic [15:0]          y1;
        logic [15:0]          colour;
        logic [SIDE_BITS-1:0] width;
        logic [SIDE_BITS-1:0] height;
    } t_job;

    typedef struct packed {
        logic busy;
        logic pixel_phase;
    } t_back_stat;

endpackage

>>> sv/rect_fill_command_stream_unit.sv
`timescale 1ns / 1ps

// Rectangle fill command stream. A fill transaction (kind 0) carries a rectangle and an RGB565
// colour; the front stage drops it if a span is zero or the origin lies off the panel, clips it
// to the right and bottom panel edges, adds the column and row offsets and queues it. Each tick
// transaction (kind 1) makes the back stage emit one byte: 0x2A, x0 and x1 big-endian, 0x2B,
// y0 and y1 big-endian, 0x2C, then width*height pixels as high byte then low byte, the last one
// flagged final_byte. A fill that reaches the back stage while a fill runs is ignored, and a
// tick while idle gives nothing. Both sides take one transaction per cycle unless stalled: the
// front register, a four-entry queue and the back output register decouple them, so the sustained
// rate is one input per clock while the queue is not full and the output is not stalled. Write the
// panel registers only while the block is idle.
module rect_fill_command_stream_unit #(
    parameter int P_MAX_SIDE = rfcs_pkg::MAX_PANEL_SIDE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rfcs_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [rfcs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rfcs_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rfcs_pkg::t_out_item                 o_out
);
    import rfcs_pkg::*;

    logic       w_push, w_full, w_pop, w_job_valid;
    t_job       w_front_job, w_head_job;
    t_back_stat w_stat;

    // Classify, clip and offset incoming transactions.
    rfcs_front #(
        .P_MAX_SIDE(P_MAX_SIDE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    // Hold classified jobs so either side can stall on its own.
    rfcs_fifo #(
        .P_WIDTH($bits(t_job)),
        .P_DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_data  (w_head_job)
    );

    // Sequence header and pixel bytes.
    rfcs_back #(
        .P_MAX_SIDE(P_MAX_SIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_stat      (w_stat)
    );

    // A fill ends only with a final pixel byte loaded into the output register.
    a_fill_ends_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(w_stat.busy)) |-> (o_out_valid && o_out.final_byte))
        else $error("fill ended without a final byte");

    // Entering the pixel phase coincides with the memory-write command.
    a_write_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(w_stat.pixel_phase))
            |-> (o_out_valid && !o_out.is_data && (o_out.out_byte == CMD_WRITE)))
        else $error("pixel phase entered without write command");

    // Command bytes are only the three window and write commands.
    a_cmd_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.is_data) |-> (!o_out.final_byte
            && ((o_out.out_byte == CMD_COLUMN) || (o_out.out_byte == CMD_ROW)
                || (o_out.out_byte == CMD_WRITE))))
        else $error("bad command byte");

endmodule

>>> sv/rfcs_front.sv
`timescale 1ns / 1ps

module rfcs_front #(
    parameter int P_MAX_SIDE = rfcs_pkg::MAX_PANEL_SIDE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rfcs_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [rfcs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rfcs_pkg::t_in_item                  i_in,
    input  logic                                i_full,
    output logic                                o_push,
    output rfcs_pkg::t_job                      o_job
);
    import rfcs_pkg::*;

    localparam int LIM = (P_MAX_SIDE < 1023) ? P_MAX_SIDE : 1023;

    logic [SIDE_BITS-1:0]   r_pw, r_ph;
    logic [OFFSET_BITS-1:0] r_coff, r_roff;
    logic                   r_fv;
    t_job                   r_job;

    logic [SIDE_BITS-1:0] w_pw, w_ph, w_rem_x, w_rem_y, w_wc, w_hc;
    logic                 w_drop;
    t_job                 w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw   <= SIDE_BITS'(240);
            r_ph   <= SIDE_BITS'(320);
            r_coff <= '0;
            r_roff <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PANEL_WIDTH:   r_pw   <= i_cfg_data;
                CFG_PANEL_HEIGHT:  r_ph   <= i_cfg_data;
                CFG_COLUMN_OFFSET: r_coff <= i_cfg_data[OFFSET_BITS-1:0];
                CFG_ROW_OFFSET:    r_roff <= i_cfg_data[OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_pw = (32'(r_pw) > LIM) ? SIDE_BITS'(LIM) : r_pw;
        w_ph = (32'(r_ph) > LIM) ? SIDE_BITS'(LIM) : r_ph;
        w_drop = (i_in.span_x == '0) || (i_in.span_y == '0)
              || (i_in.left >= 16'(w_pw)) || (i_in.top >= 16'(w_ph));
        w_rem_x = w_pw - i_in.left[SIDE_BITS-1:0];
        w_rem_y = w_ph - i_in.top[SIDE_BITS-1:0];
        // clip to right and bottom edges
        w_wc = (i_in.span_x > 16'(w_rem_x)) ? w_rem_x : i_in.span_x[SIDE_BITS-1:0];
        w_hc = (i_in.span_y > 16'(w_rem_y)) ? w_rem_y : i_in.span_y[SIDE_BITS-1:0];
        w_job.kind   = i_in.kind;
        w_job.x0     = i_in.left + 16'(r_coff);
        w_job.x1     = i_in.left + 16'(w_wc) - 16'd1 + 16'(r_coff);
        w_job.y0     = i_in.top + 16'(r_roff);
        w_job.y1     = i_in.top + 16'(w_hc) - 16'd1 + 16'(r_roff);
        w_job.colour = i_in.fill_rgb;
        w_job.width  = w_wc;
        w_job.height = w_hc;
    end

    assign o_in_stall = r_fv && i_full;
    assign o_push     = r_fv && !i_full;
    assign o_job      = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (!o_in_stall) begin
            // drop empty or off-panel requests here
            r_fv <= i_in_valid && !((i_in.kind == KIND_FILL) && w_drop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_job <= w_job;
        end
    end

endmodule

>>> sv/rfcs_fifo.sv
`timescale 1ns / 1ps

module rfcs_fifo #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = rfcs_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [P_WIDTH-1:0] i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output logic [P_WIDTH-1:0] o_data
);
    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(P_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> sv/rfcs_back.sv
`timescale 1ns / 1ps

module rfcs_back #(
    parameter int P_MAX_SIDE = rfcs_pkg::MAX_PANEL_SIDE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  rfcs_pkg::t_job        i_job,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rfcs_pkg::t_out_item   o_out,
    output rfcs_pkg::t_back_stat  o_stat
);
    import rfcs_pkg::*;

    localparam int LIM    = (P_MAX_SIDE < 1023) ? P_MAX_SIDE : 1023;
    localparam int SIDE_W = $clog2(LIM + 1);
    localparam int PIX_W  = 2 * SIDE_W;

    localparam logic [3:0] STEP_COL   = 4'd0;
    localparam logic [3:0] STEP_X0_HI = 4'd1;
    localparam logic [3:0] STEP_X0_LO = 4'd2;
    localparam logic [3:0] STEP_X1_HI = 4'd3;
    localparam logic [3:0] STEP_X1_LO = 4'd4;
    localparam logic [3:0] STEP_ROW   = 4'd5;
    localparam logic [3:0] STEP_Y0_HI = 4'd6;
    localparam logic [3:0] STEP_Y0_LO = 4'd7;
    localparam logic [3:0] STEP_Y1_HI = 4'd8;
    localparam logic [3:0] STEP_Y1_LO = 4'd9;
    localparam logic [3:0] STEP_WR    = 4'd10;
    localparam logic [3:0] STEP_PIX   = 4'd11;

    logic              r_busy, n_busy;
    logic [3:0]        r_step, n_step;
    logic [15:0]       r_x0, r_x1, r_y0, r_y1, n_x0, n_x1, n_y0, n_y1;
    logic [15:0]       r_colour, n_colour;
    logic [PIX_W-1:0]  r_pix, n_pix;
    logic              r_low, n_low;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    logic              w_take;

    assign w_take = i_job_valid && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_take;

    always_comb begin
        n_busy      = r_busy;
        n_step      = r_step;
        n_x0        = r_x0;
        n_x1        = r_x1;
        n_y0        = r_y0;
        n_y1        = r_y1;
        n_colour    = r_colour;
        n_pix       = r_pix;
        n_low       = r_low;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (w_take) begin
            if (i_job.kind == KIND_FILL) begin
                // ignore a request while a fill runs
                if (!r_busy) begin
                    n_busy   = 1'b1;
                    n_step   = STEP_COL;
                    n_x0     = i_job.x0;
                    n_x1     = i_job.x1;
                    n_y0     = i_job.y0;
                    n_y1     = i_job.y1;
                    n_colour = i_job.colour;
                    n_pix    = PIX_W'(i_job.width[SIDE_W-1:0])
                             * PIX_W'(i_job.height[SIDE_W-1:0]);
                    n_low    = 1'b0;
                end
            end else if (r_busy) begin
                n_out_valid      = 1'b1;
                n_out.is_data    = 1'b1;
                n_out.final_byte = 1'b0;
                if (r_step != STEP_PIX) begin
                    n_step = r_step + 4'd1;
                    case (r_step)
                        STEP_COL: begin
                            n_out.out_byte = CMD_COLUMN;
                            n_out.is_data  = 1'b0;
                        end
                        STEP_X0_HI: n_out.out_byte = r_x0[15:8];
                        STEP_X0_LO: n_out.out_byte = r_x0[7:0];
                        STEP_X1_HI: n_out.out_byte = r_x1[15:8];
                        STEP_X1_LO: n_out.out_byte = r_x1[7:0];
                        STEP_ROW: begin
                            n_out.out_byte = CMD_ROW;
                            n_out.is_data  = 1'b0;
                        end
                        STEP_Y0_HI: n_out.out_byte = r_y0[15:8];
                        STEP_Y0_LO: n_out.out_byte = r_y0[7:0];
                        STEP_Y1_HI: n_out.out_byte = r_y1[15:8];
                        STEP_Y1_LO: n_out.out_byte = r_y1[7:0];
                        STEP_WR: begin
                            n_out.out_byte = CMD_WRITE;
                            n_out.is_data  = 1'b0;
                        end
                        default: n_out.out_byte = r_y1[7:0];
                    endcase
                end else if (!r_low) begin
                    n_low          = 1'b1;
                    n_out.out_byte = r_colour[15:8];
                end else begin
                    n_low          = 1'b0;
                    n_out.out_byte = r_colour[7:0];
                    if (r_pix != '0) begin
                        n_pix = r_pix - 1'b1;
                    end
                    if (r_pix <= PIX_W'(1)) begin
                        n_busy           = 1'b0;
                        n_step           = STEP_COL;
                        n_out.final_byte = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_COL;
            r_pix       <= '0;
            r_low       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_pix       <= n_pix;
            r_low       <= n_low;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0     <= n_x0;
        r_x1     <= n_x1;
        r_y0     <= n_y0;
        r_y1     <= n_y1;
        r_colour <= n_colour;
        r_out    <= n_out;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;
    assign o_stat.busy        = r_busy;
    assign o_stat.pixel_phase = (r_step == STEP_PIX);

endmodule
